### hw/rtl/bsphull_pkg.sv
// ----------------------------------------------------------------------------
// bsphull_pkg: shared types and constants for the hull point classifier
// Operation codes, status codes, table defaults and the front/back queue entry.
// ----------------------------------------------------------------------------
package bsphull_pkg;

  localparam int DEF_NODE_COUNT  = 4096;
  localparam int DEF_PLANE_COUNT = 4096;
  localparam int DEF_MAX_STEPS   = 64;
  localparam int AXIAL_TYPES     = 3;

  localparam logic [1:0] OP_LOAD_PLANE = 2'd0;
  localparam logic [1:0] OP_LOAD_NODE  = 2'd1;
  localparam logic [1:0] OP_QUERY      = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_STEPS = 2'd2;

  localparam logic [0:0] CFG_FIRST_NODE = 1'd0;
  localparam logic [0:0] CFG_LAST_NODE  = 1'd1;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic               slot_ok;
    logic signed [12:0] idx;
    logic [2:0]         ptype;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic signed [23:0] pdist;
    logic [11:0]        nplane;
    logic signed [12:0] cfront;
    logic signed [12:0] cback;
  } bsphull_item_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'sh7fff;
    else if (v < -24'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

endpackage

### hw/rtl/bsp_hull_point_contents.sv
// Loads: queued, then written into the plane or node table by the back end; no result.
// Query: the walker visits one node per step (node read, plane read, compare;
// general planes add a multiply and a sum state) until it reaches a leaf, an out-of-range
// node or the 64-node step limit. One walk at a time; a waiting
// result holds off the next query, and the input stalls once the queue fills.
// Synchronous active-low reset clears control and config; tables are not cleared.
// ----------------------------------------------------------------------------
// bsp_hull_point_contents: hull point classifier top level
// Front stage, queue, and walker with plane and node tables.
// ----------------------------------------------------------------------------
module bsp_hull_point_contents import bsphull_pkg::*; #(
  parameter int NODE_COUNT  = DEF_NODE_COUNT,
  parameter int PLANE_COUNT = DEF_PLANE_COUNT,
  parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [12:0] in_entry_index,
  input  logic [2:0]         in_plane_type,
  input  logic signed [23:0] in_vec_x,
  input  logic signed [23:0] in_vec_y,
  input  logic signed [23:0] in_vec_z,
  input  logic signed [23:0] in_plane_dist,
  input  logic [11:0]        in_node_plane,
  input  logic signed [12:0] in_child_front,
  input  logic signed [12:0] in_child_back,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [4:0]  out_contents,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  logic          q_push, q_full, q_pop, q_ne;
  bsphull_item_t q_in, q_out;
  logic [11:0]   first_node_r, last_node_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_node_r <= 12'd0;
      last_node_r  <= 12'd4095;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_NODE: first_node_r <= cfg_data;
        CFG_LAST_NODE:  last_node_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  bsphull_front #(.NODE_COUNT(NODE_COUNT), .PLANE_COUNT(PLANE_COUNT)) u_front (
    .in_valid, .in_stall, .in_operation, .in_entry_index,
    .in_plane_type, .in_vec_x, .in_vec_y, .in_vec_z, .in_plane_dist,
    .in_node_plane, .in_child_front, .in_child_back,
    .q_push, .q_data(q_in), .q_full
  );

  bsphull_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
  );

  bsphull_back #(.NODE_COUNT(NODE_COUNT), .PLANE_COUNT(PLANE_COUNT),
                 .MAX_STEPS(MAX_STEPS)) u_back (
    .clk, .rst_n, .first_node(first_node_r), .last_node(last_node_r),
    .q_valid(q_ne), .q_data(q_out), .q_pop,
    .out_valid, .out_stall, .out_contents, .out_status
  );

endmodule

### hw/rtl/bsphull_front.sv
// ----------------------------------------------------------------------------
// bsphull_front: input stage
// Accepts items, checks load slots against the table sizes, pushes to queue.
// ----------------------------------------------------------------------------
module bsphull_front import bsphull_pkg::*; #(
  parameter int NODE_COUNT  = DEF_NODE_COUNT,
  parameter int PLANE_COUNT = DEF_PLANE_COUNT
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [12:0] in_entry_index,
  input  logic [2:0]         in_plane_type,
  input  logic signed [23:0] in_vec_x,
  input  logic signed [23:0] in_vec_y,
  input  logic signed [23:0] in_vec_z,
  input  logic signed [23:0] in_plane_dist,
  input  logic [11:0]        in_node_plane,
  input  logic signed [12:0] in_child_front,
  input  logic signed [12:0] in_child_back,
  output logic               q_push,
  output bsphull_item_t      q_data,
  input  logic               q_full
);

  logic slot_ok;

  always_comb begin
    slot_ok = 1'b0;
    if (!in_entry_index[12]) begin
      if (in_operation == OP_LOAD_PLANE)
        slot_ok = 32'(in_entry_index) < PLANE_COUNT;
      else
        slot_ok = 32'(in_entry_index) < NODE_COUNT;
    end
  end

  assign in_stall = q_full;
  // unknown operation is dropped here
  assign q_push   = in_valid && !q_full && (in_operation != OP_NONE);

  always_comb begin
    q_data.op      = in_operation;
    q_data.slot_ok = slot_ok;
    q_data.idx     = in_entry_index;
    q_data.ptype   = in_plane_type;
    q_data.vx      = in_vec_x;
    q_data.vy      = in_vec_y;
    q_data.vz      = in_vec_z;
    q_data.pdist   = in_plane_dist;
    q_data.nplane  = in_node_plane;
    q_data.cfront  = in_child_front;
    q_data.cback   = in_child_back;
  end

endmodule

### hw/rtl/bsphull_queue.sv
// ----------------------------------------------------------------------------
// bsphull_queue: two-entry queue between front and back
// ----------------------------------------------------------------------------
module bsphull_queue import bsphull_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsphull_item_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bsphull_item_t pop_data
);

  bsphull_item_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/bsphull_back.sv
// ----------------------------------------------------------------------------
// bsphull_back: table store and tree walker
// Writes loads into the plane/node memories and walks queries node by node.
// ----------------------------------------------------------------------------
module bsphull_back import bsphull_pkg::*; #(
  parameter int NODE_COUNT  = DEF_NODE_COUNT,
  parameter int PLANE_COUNT = DEF_PLANE_COUNT,
  parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [11:0]        first_node,
  input  logic [11:0]        last_node,
  input  logic               q_valid,
  input  bsphull_item_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [4:0]  out_contents,
  output logic [1:0]         out_status
);

  localparam int NAW = $clog2(NODE_COUNT);
  localparam int PAW = $clog2(PLANE_COUNT);
  localparam int SW  = $clog2(MAX_STEPS + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_NODE, S_PLANE, S_MUL, S_SUM, S_DONE}
    state_t;

  // plane word: type, distance, normals
  logic [2:0]         pk_mem [PLANE_COUNT];
  logic signed [23:0] pd_mem [PLANE_COUNT];
  logic [47:0]        pn_mem [PLANE_COUNT];
  logic [37:0]        nd_mem [NODE_COUNT];

  state_t             state_r;
  logic signed [12:0] num_r;
  logic [SW-1:0]      steps_r;
  logic signed [23:0] px_r, py_r, pz_r;
  logic [37:0]        node_r;
  logic               pvalid_r;
  logic [2:0]         pk_r;
  logic signed [23:0] pd_r;
  logic [47:0]        pn_r;
  logic signed [39:0] m0_r, m1_r, m2_r;
  logic signed [4:0]  cont_r;
  logic [1:0]         stat_r;
  logic               out_valid_r;

  logic [11:0]        nps;
  logic signed [12:0] child_f, child_b;
  logic [2:0]         kind;
  logic signed [23:0] dist_e;
  logic signed [41:0] dot;
  logic signed [23:0] coord;
  logic               neg_ax;
  logic               nd_ok;

  assign nps     = node_r[37:26];
  assign child_f = node_r[25:13];
  assign child_b = node_r[12:0];
  assign kind    = pvalid_r ? pk_r : 3'd0;
  assign dist_e  = pvalid_r ? pd_r : 24'sd0;

  always_comb begin
    case (kind)
      3'd0:    coord = px_r;
      3'd1:    coord = py_r;
      default: coord = pz_r;
    endcase
  end
  assign neg_ax = 25'(coord) - 25'(dist_e) < 0;
  assign dot    = 42'(m0_r) + 42'(m1_r) + 42'(m2_r) - (42'(dist_e) <<< 15);

  always_comb begin
    nd_ok = !num_r[12] && (num_r[11:0] >= first_node) && (num_r[11:0] <= last_node)
            && (32'(num_r) < NODE_COUNT);
  end

  assign q_pop     = q_valid && state_r == S_IDLE && !(q_data.op == OP_QUERY && out_valid_r);
  assign out_valid = out_valid_r;
  assign out_contents = cont_r;
  assign out_status   = stat_r;

  // memory writes and reads
  always_ff @(posedge clk) begin
    if (q_pop && q_data.slot_ok && q_data.op == OP_LOAD_PLANE) begin
      pk_mem[q_data.idx[PAW-1:0]] <= q_data.ptype;
      pd_mem[q_data.idx[PAW-1:0]] <= q_data.pdist;
      pn_mem[q_data.idx[PAW-1:0]] <= {sat16(q_data.vx), sat16(q_data.vy), sat16(q_data.vz)};
    end
    if (q_pop && q_data.slot_ok && q_data.op == OP_LOAD_NODE)
      nd_mem[q_data.idx[NAW-1:0]] <= {q_data.nplane, q_data.cfront, q_data.cback};
    if (state_r == S_CHECK) node_r <= nd_mem[num_r[NAW-1:0]];
    if (state_r == S_NODE) begin
      pvalid_r <= 32'(nps) < PLANE_COUNT;
      pk_r <= pk_mem[nps[PAW-1:0]];
      pd_r <= pd_mem[nps[PAW-1:0]];
      pn_r <= pn_mem[nps[PAW-1:0]];
    end
    if (state_r == S_PLANE) begin
      m0_r <= $signed(pvalid_r ? pn_r[47:32] : 16'sd0) * px_r;
      m1_r <= $signed(pvalid_r ? pn_r[31:16] : 16'sd0) * py_r;
      m2_r <= $signed(pvalid_r ? pn_r[15:0]  : 16'sd0) * pz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      num_r       <= '0;
      steps_r     <= '0;
      cont_r      <= '0;
      stat_r      <= ST_OK;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && q_data.op == OP_QUERY) begin
            num_r   <= q_data.idx;
            steps_r <= '0;
            px_r    <= q_data.vx;
            py_r    <= q_data.vy;
            pz_r    <= q_data.vz;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (num_r[12]) begin
            cont_r  <= (num_r < -13'sd16) ? -5'sd16 : num_r[4:0];
            stat_r  <= ST_OK;
            state_r <= S_DONE;
          end else if (32'(steps_r) >= MAX_STEPS) begin
            cont_r  <= '0;
            stat_r  <= ST_STEPS;
            state_r <= S_DONE;
          end else if (!nd_ok) begin
            cont_r  <= '0;
            stat_r  <= ST_RANGE;
            state_r <= S_DONE;
          end else begin
            steps_r <= steps_r + 1'b1;
            state_r <= S_NODE;
          end
        end
        S_NODE:  state_r <= S_PLANE;
        S_PLANE: begin
          if (kind < 3'(AXIAL_TYPES)) begin
            num_r   <= neg_ax ? child_b : child_f;
            state_r <= S_CHECK;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_SUM;
        S_SUM: begin
          num_r   <= (dot < 0) ? child_b : child_f;
          state_r <= S_CHECK;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/bsphull_checker.sv
// ----------------------------------------------------------------------------
// bsphull_checker: port-level checks for the hull point classifier
// ----------------------------------------------------------------------------
module bsphull_checker import bsphull_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [4:0] out_contents,
  input logic [1:0]        out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_contents == 5'sd0)
    else $error("contents not cleared on error");

  a_leaf_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_contents[4])
    else $error("leaf contents not negative");

endmodule

bind bsp_hull_point_contents bsphull_checker u_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_contents, .out_status
);
